@@ rtl/blsp_pkg.sv @@
package blsp_pkg;

  // Default number of fractional bits of the fixed point format.
  localparam int FRAC_BITS_DEF = 16;

  // Port widths.
  localparam int NOISE_W     = 20;
  localparam int WORD_W      = 32;
  localparam int KE_W        = 31;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUBIC  = 3'd0,
    REG_LINEAR = 3'd1,
    REG_HDTM   = 3'd2,
    REG_HDT    = 3'd3,
    REG_FRIC   = 3'd4,
    REG_NOISE  = 3'd5,
    REG_HMASS  = 3'd6
  } cfg_reg_e;

  // Multiplier operand sources.
  typedef enum logic [3:0] {
    OPND_X,
    OPND_V,
    OPND_T,
    OPND_ETA,
    OPND_CUBIC,
    OPND_LINEAR,
    OPND_HDTM,
    OPND_HDT,
    OPND_FRIC,
    OPND_NOISE,
    OPND_HMASS
  } opnd_e;

  // Writeback operations applied to the registered product.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_T_RND,        // t = round(p)
    WB_T_ADD,        // t = sat(t + round(p))
    WB_K_RND,        // kick = round(p)
    WB_V_SUBK,       // v = sat(v - kick)
    WB_T_RND_V_SUBK, // both of the above at once
    WB_KE_RND,       // ke = round(p)
    WB_X_ADD,        // x = sat(x + round(p))
    WB_V_RND,        // v = round(p)
    WB_V_ADD         // v = sat(v + round(p))
  } wb_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MXX, S_WX2, S_MX3, S_WX3,
    S_MC,  S_WC,  S_ML,  S_WF,
    S_MK,  S_WK,  S_V1,
    S_MVV, S_WVV, S_MKE, S_WKE,
    S_MD1, S_WD1, S_MFR, S_WFR,
    S_MN,  S_WN,  S_MD2, S_WD2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  start;   // a word was accepted: latch noise, clear kinetic energy and overflow
    logic  load;    // an accepted load word loads position and velocity
    logic  mul_en;
    opnd_e a_sel;
    opnd_e b_sel;
    wb_e   wb;
    logic  capture; // copy state into the output register
  } dp_cmd_t;

endpackage

@@ rtl/blsp_ctrl.sv @@
module blsp_ctrl import blsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_op_i ? S_DONE : S_MXX;
        end
      end
      S_MXX: state_d = S_WX2;
      S_WX2: state_d = S_MX3;
      S_MX3: state_d = S_WX3;
      S_WX3: state_d = S_MC;
      S_MC:  state_d = S_WC;
      S_WC:  state_d = S_ML;
      S_ML:  state_d = S_WF;
      S_WF:  state_d = S_MK;
      S_MK:  state_d = S_WK;
      S_WK:  state_d = S_V1;
      S_V1:  state_d = S_MVV;
      S_MVV: state_d = S_WVV;
      S_WVV: state_d = S_MKE;
      S_MKE: state_d = S_WKE;
      S_WKE: state_d = S_MD1;
      S_MD1: state_d = S_WD1;
      S_WD1: state_d = S_MFR;
      S_MFR: state_d = S_WFR;
      S_WFR: state_d = S_MN;
      S_MN:  state_d = S_WN;
      S_WN:  state_d = S_MD2;
      S_MD2: state_d = S_WD2;
      S_WD2: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.a_sel   = OPND_X;
    cmd_o.b_sel   = OPND_X;
    cmd_o.wb      = WB_NONE;
    cmd_o.start   = accept;
    cmd_o.load    = accept && in_op_i;
    unique case (state_q)
      S_MXX: begin
        cmd_o.mul_en = 1'b1;
      end
      S_MX3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_T;
      end
      S_MC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_CUBIC;
        cmd_o.b_sel  = OPND_T;
      end
      S_ML: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_LINEAR;
      end
      S_MK: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_HDTM;
        cmd_o.b_sel  = OPND_T;
      end
      S_MVV: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_V;
        cmd_o.b_sel  = OPND_V;
      end
      S_MKE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_HMASS;
        cmd_o.b_sel  = OPND_T;
      end
      S_MD1, S_MD2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_HDT;
        cmd_o.b_sel  = OPND_V;
      end
      S_MFR: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_FRIC;
        cmd_o.b_sel  = OPND_V;
      end
      S_MN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = OPND_NOISE;
        cmd_o.b_sel  = OPND_ETA;
      end
      S_WX2, S_WX3, S_WC: cmd_o.wb = WB_T_RND;
      S_WF:               cmd_o.wb = WB_T_ADD;
      S_WK:               cmd_o.wb = WB_K_RND;
      S_V1:               cmd_o.wb = WB_V_SUBK;
      S_WVV:              cmd_o.wb = WB_T_RND_V_SUBK;
      S_WKE:              cmd_o.wb = WB_KE_RND;
      S_WD1, S_WD2:       cmd_o.wb = WB_X_ADD;
      S_WFR:              cmd_o.wb = WB_V_RND;
      S_WN:               cmd_o.wb = WB_V_ADD;
      S_DONE:             cmd_o.capture = out_free;
      S_IDLE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/blsp_datapath.sv @@
module blsp_datapath import blsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  dp_cmd_t                      cmd_i,
  input  logic signed [NOISE_W-1:0]    in_noise_i,
  input  logic signed [WORD_W-1:0]     in_pos_i,
  input  logic signed [WORD_W-1:0]     in_vel_i,
  output logic signed [WORD_W-1:0]     out_pos_o,
  output logic signed [WORD_W-1:0]     out_vel_o,
  output logic [KE_W-1:0]              out_ke_o,
  output logic                         out_ovf_o
);

  // The friction register must hold 1.0 at any fraction width.
  localparam int FricW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
  localparam logic signed [63:0] RndHalf  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [WORD_W-1:0]  OneRst   = WORD_W'(64'd1 << FRAC_BITS);
  localparam logic [KE_W-1:0]    HundRst  = KE_W'((64'd1 << FRAC_BITS) / 100);
  localparam logic [KE_W-1:0]    HalfRst  = KE_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [FricW-1:0]   FricRst  = FricW'(64'd1 << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] MaxW = 32'sh7FFFFFFF;
  localparam logic signed [WORD_W-1:0] MinW = 32'sh80000000;

  typedef struct packed {
    logic                     ovf;
    logic signed [WORD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [63:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[WORD_W-1:0];
    if (v > 64'sh000000007FFFFFFF) begin
      r.ovf = 1'b1;
      r.val = MaxW;
    end else if (v < 64'shFFFFFFFF80000000) begin
      r.ovf = 1'b1;
      r.val = MinW;
    end
    return r;
  endfunction

  function automatic sat_t sat_sum(input logic signed [WORD_W:0] s);
    sat_t r;
    r.ovf = (s[WORD_W] != s[WORD_W-1]);
    r.val = s[WORD_W-1:0];
    if (r.ovf) begin
      r.val = s[WORD_W] ? MinW : MaxW;
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [WORD_W-1:0] cubic_q, linear_q;
  logic [KE_W-1:0]          hdtm_q, hdt_q, noise_q, hmass_q;
  logic [FricW-1:0]         fric_q;

  // Particle state and working registers.
  logic signed [WORD_W-1:0]  x_q, x_d, v_q, v_d, t_q, t_d, k_q, k_d;
  logic [KE_W-1:0]           ke_q, ke_d;
  logic                      ovf_q, ovf_d;
  logic signed [NOISE_W-1:0] eta_q;
  logic signed [63:0]        p_q;

  logic signed [WORD_W-1:0] opnd_a, opnd_b;
  logic signed [63:0]       prod_rnd, prod_sh;
  logic signed [WORD_W-1:0] add_base;
  sat_t                     rnd, acc, vsub;
  logic                     wb_ovf;

  function automatic logic signed [WORD_W-1:0] pick(
    input opnd_e                     sel,
    input logic signed [WORD_W-1:0]  x,
    input logic signed [WORD_W-1:0]  v,
    input logic signed [WORD_W-1:0]  t,
    input logic signed [NOISE_W-1:0] eta
  );
    logic signed [WORD_W-1:0] r;
    case (sel)
      OPND_X:      r = x;
      OPND_V:      r = v;
      OPND_T:      r = t;
      OPND_ETA:    r = {{(WORD_W-NOISE_W){eta[NOISE_W-1]}}, eta};
      OPND_CUBIC:  r = cubic_q;
      OPND_LINEAR: r = linear_q;
      OPND_HDTM:   r = {1'b0, hdtm_q};
      OPND_HDT:    r = {1'b0, hdt_q};
      OPND_FRIC:   r = {{(WORD_W-FricW){1'b0}}, fric_q};
      OPND_NOISE:  r = {1'b0, noise_q};
      OPND_HMASS:  r = {1'b0, hmass_q};
      default:     r = '0;
    endcase
    return r;
  endfunction

  assign opnd_a = pick(cmd_i.a_sel, x_q, v_q, t_q, eta_q);
  assign opnd_b = pick(cmd_i.b_sel, x_q, v_q, t_q, eta_q);

  // Round half up at the binary point, then floor by arithmetic shift.
  assign prod_rnd = p_q + RndHalf;
  assign prod_sh  = prod_rnd >>> FRAC_BITS;
  assign rnd      = sat_wide(prod_sh);

  always_comb begin
    case (cmd_i.wb)
      WB_X_ADD: add_base = x_q;
      WB_V_ADD: add_base = v_q;
      default:  add_base = t_q;
    endcase
  end

  assign acc  = sat_sum({add_base[WORD_W-1], add_base} + {rnd.val[WORD_W-1], rnd.val});
  assign vsub = sat_sum({v_q[WORD_W-1], v_q} - {k_q[WORD_W-1], k_q});

  always_comb begin
    x_d    = x_q;
    v_d    = v_q;
    t_d    = t_q;
    k_d    = k_q;
    ke_d   = ke_q;
    wb_ovf = 1'b0;
    case (cmd_i.wb)
      WB_T_RND: begin
        t_d    = rnd.val;
        wb_ovf = rnd.ovf;
      end
      WB_T_ADD: begin
        t_d    = acc.val;
        wb_ovf = rnd.ovf | acc.ovf;
      end
      WB_K_RND: begin
        k_d    = rnd.val;
        wb_ovf = rnd.ovf;
      end
      WB_V_SUBK: begin
        v_d    = vsub.val;
        wb_ovf = vsub.ovf;
      end
      WB_T_RND_V_SUBK: begin
        t_d    = rnd.val;
        v_d    = vsub.val;
        wb_ovf = rnd.ovf | vsub.ovf;
      end
      WB_KE_RND: begin
        // Half mass and a square are both non-negative.
        ke_d   = rnd.val[KE_W-1:0];
        wb_ovf = rnd.ovf;
      end
      WB_X_ADD: begin
        x_d    = acc.val;
        wb_ovf = rnd.ovf | acc.ovf;
      end
      WB_V_RND: begin
        v_d    = rnd.val;
        wb_ovf = rnd.ovf;
      end
      WB_V_ADD: begin
        v_d    = acc.val;
        wb_ovf = rnd.ovf | acc.ovf;
      end
      default: ;
    endcase
    ovf_d = ovf_q | wb_ovf;
    if (cmd_i.start) begin
      ke_d  = '0;
      ovf_d = 1'b0;
    end
    if (cmd_i.load) begin
      x_d = in_pos_i;
      v_d = in_vel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cubic_q  <= '0;
      linear_q <= OneRst;
      hdtm_q   <= HundRst;
      hdt_q    <= HundRst;
      fric_q   <= FricRst;
      noise_q  <= '0;
      hmass_q  <= HalfRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CUBIC:  cubic_q  <= cfg_data_i;
        REG_LINEAR: linear_q <= cfg_data_i;
        REG_HDTM:   hdtm_q   <= cfg_data_i[KE_W-1:0];
        REG_HDT:    hdt_q    <= cfg_data_i[KE_W-1:0];
        REG_FRIC:   fric_q   <= FricW'(cfg_data_i[16:0]);
        REG_NOISE:  noise_q  <= cfg_data_i[KE_W-1:0];
        REG_HMASS:  hmass_q  <= cfg_data_i[KE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      v_q   <= '0;
      ovf_q <= 1'b0;
    end else begin
      x_q   <= x_d;
      v_q   <= v_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    k_q  <= k_d;
    ke_q <= ke_d;
    if (cmd_i.start) begin
      eta_q <= in_noise_i;
    end
    if (cmd_i.mul_en) begin
      p_q <= opnd_a * opnd_b;
    end
    if (cmd_i.capture) begin
      out_pos_o <= x_q;
      out_vel_o <= v_q;
      out_ke_o  <= ke_q;
      out_ovf_o <= ovf_q;
    end
  end

endmodule

@@ rtl/baoa_langevin_step.sv @@
// One particle advanced by one BAOA Langevin step per step input word.
// Input stream (s_axis): tuser is the opcode, 0 for a step and 1 for a load.
// A step draws on the noise sample; a load replaces position and velocity.
// Output stream (m_axis): one word per input with position, velocity, the
// midpoint kinetic energy and a saturation flag in tuser.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; the user must keep to this, as the block does not enforce
// it. Indexes seven and up are ignored. A step result enters the output
// register once the sequencer has run its multiply and writeback states; a
// load goes straight from idle to the done state. Both wait there until the
// output register is free. The sequencer shares the single 32x32 multiplier
// among eleven products, each formed in a multiply state and rounded and
// written back in a writeback state. s_axis_tready is high only while the
// sequencer is idle. A finished word waits in the output register, so the
// next input is taken while the receiver stalls; the following result then
// holds until the word is taken. Reset restores the default coefficients and
// clears position, velocity and the output valid.
module baoa_langevin_step import blsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // noise_sample, load_position, load_velocity, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // position, velocity, kinetic_energy, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // overflow
  output logic                   m_axis_tuser,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_cmd_t                  cmd;
  logic signed [WORD_W-1:0] pos, vel;
  logic [KE_W-1:0]          ke;

  blsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  blsp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .in_noise_i (s_axis_tdata[NOISE_W-1:0]),
    .in_pos_i   (s_axis_tdata[NOISE_W+WORD_W-1:NOISE_W]),
    .in_vel_i   (s_axis_tdata[NOISE_W+2*WORD_W-1:NOISE_W+WORD_W]),
    .out_pos_o  (pos),
    .out_vel_o  (vel),
    .out_ke_o   (ke),
    .out_ovf_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, ke, vel, pos};

endmodule

@@ rtl/blsp_checker.sv @@
module blsp_checker import blsp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // The sequencer handles one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a word is in flight");

  // A new result appears exactly when the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while the sequencer is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

endmodule

bind baoa_langevin_step blsp_checker u_blsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blsp_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int LIMIT = 500_000;
  localparam int N_PHASES = 8;
  localparam int WORDS_PER_PHASE = 150;
  localparam int MAX_REPORTS = 30;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] vel;
    logic [KE_W-1:0]   ke;
    logic              ovf;
  } step_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // A register row carries its write data in pos.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  op;
    logic [NOISE_W-1:0]    noise;
    logic [WORD_W-1:0]     pos;
    logic [WORD_W-1:0]     vel;
    logic                  typed;
    step_result_t          want;
  } row_t;

  typedef enum int {RX_EAGER, RX_CHOPPY, RX_LAZY} rx_mode_e;

  localparam step_result_t ZERO_RESULT = '0;
  localparam int N_DIRECTED = 28;

  // Loads and the first step after reset have results that are known
  // outright; every other word row is checked against the predictor.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h7FFFF, 32'h0001_0000, 32'h0000_0000, 1'b1,
      '{32'h0001_0000, 32'h0000_0000, 31'h0, 1'b0}},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h00000, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h80000, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h80000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 1'b0}},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h7FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h00000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h8000_0000, 31'h0, 1'b0}},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h00000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_CUBIC,  OP_STEP, 20'h00000, 32'h0004_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_LINEAR, OP_STEP, 20'h00000, 32'hFFFE_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_NOISE,  OP_STEP, 20'h00000, 32'h0000_8000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h12345, 32'h0001_8000, 32'hFFFF_C000, 1'b1,
      '{32'h0001_8000, 32'hFFFF_C000, 31'h0, 1'b0}},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h7FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h80000, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_FRIC,   OP_STEP, 20'h00000, 32'h0001_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_SPARE,  OP_STEP, 20'h00000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h00001, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_HDTM,   OP_STEP, 20'h00000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_HDT,    OP_STEP, 20'h00000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_HMASS,  OP_STEP, 20'h00000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'hFFFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h55555, 32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RESULT},
    '{ROW_REG,  REG_FRIC,   OP_STEP, 20'h00000, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_REG,  REG_NOISE,  OP_STEP, 20'h00000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h7FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'h80000, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT},
    '{ROW_WORD, REG_CUBIC,  OP_LOAD, 20'h00000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 31'h0, 1'b0}},
    '{ROW_WORD, REG_CUBIC,  OP_STEP, 20'hAAAAA, 32'h0000_0000, 32'h0000_0000, 1'b0, ZERO_RESULT}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // noise_sample, load_position, load_velocity, zero fill
  logic                   s_axis_tuser = 1'b0; // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // position, velocity, kinetic_energy, zero fill
  logic                   m_axis_tuser;       // overflow
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = REG_CUBIC;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  baoa_langevin_step u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state: register copies and the particle.
  longint coef_cubic = 0;
  longint coef_linear = longint'(1) << FRAC;
  longint kick_scale = (longint'(1) << FRAC) / 100;
  longint drift_scale = (longint'(1) << FRAC) / 100;
  longint damping = longint'(1) << FRAC;
  longint noise_gain = 0;
  longint half_mass = longint'(1) << (FRAC - 1);
  longint particle_x = 0;
  longint particle_v = 0;
  bit     sat_seen;

  step_result_t expected_words [$];
  rx_mode_e     rx_mode = RX_EAGER;
  int           rx_run = 0;
  int           errors = 0;
  int           cycle_count = 0;
  int           n_steps = 0;
  int           n_loads = 0;
  int           n_writes = 0;
  int           n_settings = 1;
  int           n_checked = 0;
  int           n_sat = 0;

  function automatic longint clamp32(longint v);
    if (v > SAT_HI) begin
      sat_seen = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      sat_seen = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  // Round half up at the binary point, then saturate.
  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b + (longint'(1) << (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic step_result_t predict_word(logic op, logic [NOISE_W-1:0] noise,
                                                logic [WORD_W-1:0] lp, logic [WORD_W-1:0] lv);
    longint x, v, x3, kick, eta, ke;
    step_result_t r;
    sat_seen = 1'b0;
    ke = 0;
    if (op == OP_LOAD) begin
      particle_x = $signed(lp);
      particle_v = $signed(lv);
    end else begin
      x = particle_x;
      v = particle_v;
      eta = $signed(noise);
      x3 = qmul(qmul(x, x), x);
      // Both half kicks use the force at the old position.
      kick = qmul(kick_scale, clamp32(qmul(coef_cubic, x3) + qmul(coef_linear, x)));
      v = clamp32(v - kick);
      ke = qmul(half_mass, qmul(v, v));
      v = clamp32(v - kick);
      x = clamp32(x + qmul(drift_scale, v));
      v = qmul(damping, v);
      v = clamp32(v + qmul(noise_gain, eta));
      x = clamp32(x + qmul(drift_scale, v));
      particle_x = x;
      particle_v = v;
    end
    r.pos = particle_x[WORD_W-1:0];
    r.vel = particle_v[WORD_W-1:0];
    r.ke  = ke[KE_W-1:0];
    r.ovf = sat_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_CUBIC:  coef_cubic = $signed(data);
      REG_LINEAR: coef_linear = $signed(data);
      REG_HDTM:   kick_scale = data[30:0];
      REG_HDT:    drift_scale = data[30:0];
      REG_FRIC:   damping = data[16:0];
      REG_NOISE:  noise_gain = data[30:0];
      REG_HMASS:  half_mass = data[30:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(logic op, logic [NOISE_W-1:0] noise, logic [WORD_W-1:0] lp,
                           logic [WORD_W-1:0] lv, bit typed, step_result_t want);
    step_result_t got;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, lv, lp, noise};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    got = predict_word(op, noise, lp, lv);
    expected_words.push_back(typed ? want : got);
    if (op == OP_LOAD) n_loads++;
    else n_steps++;
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= ($urandom & 1) != 0;
      s_axis_tdata  <= {4'h0, 32'($urandom), 32'($urandom), NOISE_W'($urandom)};
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Every word yields a result, so an empty queue means the block is idle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] corner_value(bit is_signed);
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return is_signed ? 32'h8000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(negedge clk_i) begin : receiver
    if (rx_run != 0) begin
      rx_run--;
    end else begin
      case (rx_mode)
        RX_EAGER: m_axis_tready <= 1'b1;
        RX_CHOPPY: begin
          m_axis_tready <= ($urandom & 1) != 0;
          rx_run = $urandom_range(0, 2);
        end
        default: begin
          // Long stalls broken by short open windows.
          if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            rx_run = $urandom_range(2, 14);
          end else begin
            m_axis_tready <= 1'b1;
            rx_run = $urandom_range(0, 2);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    step_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", m_axis_tdata));
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (m_axis_tdata[31:0] !== want.pos)
          report_mismatch($sformatf("result %0d: position %h, expected %h",
                                    n_checked, m_axis_tdata[31:0], want.pos));
        if (m_axis_tdata[63:32] !== want.vel)
          report_mismatch($sformatf("result %0d: velocity %h, expected %h",
                                    n_checked, m_axis_tdata[63:32], want.vel));
        if (m_axis_tdata[94:64] !== want.ke)
          report_mismatch($sformatf("result %0d: kinetic energy %h, expected %h",
                                    n_checked, m_axis_tdata[94:64], want.ke));
        if (m_axis_tuser !== want.ovf)
          report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                    n_checked, m_axis_tuser, want.ovf));
        if (m_axis_tuser === 1'b1) n_sat++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    row_t               row;
    bit                 writing;
    int                 gap_max;
    int                 phase_words;
    logic               op;
    logic [NOISE_W-1:0] noise;
    logic [WORD_W-1:0]  lp;
    logic [WORD_W-1:0]  lv;
    writing = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
        end
        write_reg(row.idx, row.pos);
      end else begin
        if (writing) begin
          end_writes();
          writing = 1'b0;
          n_settings++;
        end
        send_word(row.op, row.noise, row.pos, row.vel, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph % 3 == 2) begin
        write_reg(REG_CUBIC, corner_value(1'b1));
        write_reg(REG_LINEAR, corner_value(1'b1));
        write_reg(REG_HDTM, corner_value(1'b0));
        write_reg(REG_HDT, corner_value(1'b0));
        case ($urandom_range(0, 3))
          0: write_reg(REG_FRIC, 32'h0000_0000);
          1: write_reg(REG_FRIC, 32'h0001_0000);
          2: write_reg(REG_FRIC, 32'h0001_FFFF);
          default: write_reg(REG_FRIC, $urandom);
        endcase
        write_reg(REG_NOISE, corner_value(1'b0));
        write_reg(REG_HMASS, corner_value(1'b0));
      end else begin
        // Physically plausible settings: small time step, light damping.
        write_reg(REG_CUBIC, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        write_reg(REG_LINEAR, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        write_reg(REG_HDTM, $urandom_range(0, 32'h0000_2000));
        write_reg(REG_HDT, $urandom_range(0, 32'h0000_2000));
        write_reg(REG_FRIC, $urandom_range(32'h0000_E000, 32'h0001_0000));
        write_reg(REG_NOISE, $urandom_range(0, 32'h0000_4000));
        write_reg(REG_HMASS, $urandom_range(0, 32'h0002_0000));
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_SPARE, $urandom);
      end_writes();
      n_settings++;

      if (ph % 4 == 1) begin
        gap_max = 0;
        rx_mode = RX_EAGER;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_max = 3;
          1: gap_max = 12;
          default: gap_max = 40;
        endcase
        rx_mode = rx_mode_e'($urandom_range(0, 2));
      end

      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        repeat ($urandom_range(1, 12)) begin
          op = (phase_words == 0 || $urandom_range(0, 11) == 0) ? OP_LOAD : OP_STEP;
          noise = NOISE_W'($urandom);
          if ($urandom_range(0, 3) == 0) begin
            lp = $urandom;
            lv = $urandom;
          end else begin
            lp = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            lv = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          end
          send_word(op, noise, lp, lv, 1'b0, ZERO_RESULT);
          phase_words++;
        end
        hold_off($urandom_range(0, gap_max));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_words.size()));
    $display("Checked %0d results from %0d steps and %0d loads; %0d flagged saturation.",
             n_checked, n_steps, n_loads, n_sat);
    $display("Made %0d register writes across %0d settings, %0d mismatches.",
             n_writes, n_settings, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/blsp_pkg.sv
rtl/blsp_ctrl.sv
rtl/blsp_datapath.sv
rtl/baoa_langevin_step.sv
rtl/blsp_checker.sv
dv/tb_top.sv
